// ===== rtl/core/abs_pkg.sv =====
// ----------------------------------------------------------------------------
// abs_pkg
// Shared types and constants for the affine bilinear sampler.
// ----------------------------------------------------------------------------
package abs_pkg;

  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_SAMPLE = 2'd1;
  localparam logic [1:0] REQ_GRAD   = 2'd2;

  localparam logic [2:0] CFG_A_XX     = 3'd0;
  localparam logic [2:0] CFG_A_XY     = 3'd1;
  localparam logic [2:0] CFG_A_YX     = 3'd2;
  localparam logic [2:0] CFG_A_YY     = 3'd3;
  localparam logic [2:0] CFG_SHIFT_X  = 3'd4;
  localparam logic [2:0] CFG_SHIFT_Y  = 3'd5;
  localparam logic [2:0] CFG_CENTER_X = 3'd6;
  localparam logic [2:0] CFG_CENTER_Y = 3'd7;

  localparam int FRAC_BITS = 12;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 24;
  localparam int POS_W = 12;
  localparam int PIX_W = 16;
  localparam int SAMPLE_W = 28;
  localparam int GRAD_W = 29;
  // Width of the mapped coordinate: 16x13 product, two of them, plus a 25-bit offset.
  localparam int MAP_W = 32;

  typedef struct packed {
    logic signed [15:0] a_xx;
    logic signed [15:0] a_xy;
    logic signed [15:0] a_yx;
    logic signed [15:0] a_yy;
    logic signed [24:0] off_x;
    logic signed [24:0] off_y;
  } xform_t;

  typedef struct packed {
    logic signed [MAP_W-1:0] px;
    logic signed [MAP_W-1:0] py;
  } point_t;

endpackage

// ===== rtl/core/abs_ram.sv =====
// ----------------------------------------------------------------------------
// abs_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module abs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/core/abs_map.sv =====
// ----------------------------------------------------------------------------
// abs_map
// Affine mapping of an integer point, two registered stages.
// ----------------------------------------------------------------------------
module abs_map
  import abs_pkg::*;
(
  input  logic                    clk,
  input  xform_t                  xf,
  input  logic signed [POS_W:0]   qx,
  input  logic signed [POS_W:0]   qy,
  output point_t                  pt
);

  logic signed [MAP_W-1:0] pxx, pxy, pyx, pyy;

  always_ff @(posedge clk) begin
    pxx <= MAP_W'(xf.a_xx * qx);
    pxy <= MAP_W'(xf.a_xy * qy);
    pyx <= MAP_W'(xf.a_yx * qx);
    pyy <= MAP_W'(xf.a_yy * qy);
    pt.px <= pxx + pxy + MAP_W'(xf.off_x);
    pt.py <= pyx + pyy + MAP_W'(xf.off_y);
  end

endmodule

// ===== rtl/core/affine_bilinear_sampler_top.sv =====
// ----------------------------------------------------------------------------
// affine_bilinear_sampler_top
// Pixel store with affine-warped bilinear sampling and gradients.
// ----------------------------------------------------------------------------
// channel | direction | handshake     | payload
// in      | input     | valid / stall | req_type pos_x pos_y pixel_in
// out     | output    | valid / stall | result_kind sample_value grad_x grad_y
// cfg     | input     | valid / ready | cfg_index cfg_data
//
// A write is taken while idle and stored at its input transfer. A sample
// goes through the states map, read, M1, M2, M3 and accumulate before its
// result is shown; a gradient does this for four points. Each sample maps the
// point, reads 4 pixels through the single pixel RAM port and interpolates.
// Reset sets the state to idle and the transform to identity with zero
// offsets; the pixel RAM is not cleared. Output stall holds the result
// register; no input transfer comes before the cycle after the result one.
module affine_bilinear_sampler_top
  import abs_pkg::*;
#(
  parameter int IMG_WIDTH = 256,
  parameter int IMG_HEIGHT = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  req_type,
  input  logic signed [POS_W-1:0]     pos_x,
  input  logic signed [POS_W-1:0]     pos_y,
  input  logic [PIX_W-1:0]            pixel_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        result_kind,
  output logic [SAMPLE_W-1:0]         sample_value,
  output logic signed [GRAD_W-1:0]    grad_x,
  output logic signed [GRAD_W-1:0]    grad_y,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  localparam int DEPTH = IMG_WIDTH * IMG_HEIGHT;
  localparam int AW = $clog2(DEPTH);
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MAP  = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_M1   = 4'd3;
  localparam logic [3:0] S_M2   = 4'd4;
  localparam logic [3:0] S_M3   = 4'd5;
  localparam logic [3:0] S_ACC  = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;

  xform_t xf;
  logic signed [23:0] sh_x, sh_y, ce_x, ce_y;
  logic [3:0] state;
  logic [1:0] kind;
  logic signed [POS_W-1:0] bx, by;
  logic [1:0] sidx;
  logic [1:0] mcnt;
  logic [2:0] rcnt;
  logic signed [POS_W:0] qx, qy;
  point_t pt;
  logic signed [MAP_W-FRAC_BITS-1:0] ix, iy;
  logic [FRAC_BITS-1:0] fx, fy;
  logic [PIX_W-1:0] p [4];
  logic [AW-1:0] ram_addr;
  logic ram_we;
  logic [PIX_W-1:0] ram_rdata;
  logic signed [MAP_W-FRAC_BITS:0] rx, ry;
  logic rin;
  logic [PIX_W+FRAC_BITS:0] m0, m1, m2, m3, r1, r2;
  logic [2*(PIX_W+FRAC_BITS)+1:0] t1, t2;
  logic [SAMPLE_W-1:0] sval, s0;
  logic signed [GRAD_W:0] dx;

  assign in_stall = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      xf.a_xx <= 16'sd1 <<< FRAC_BITS;
      xf.a_xy <= '0;
      xf.a_yx <= '0;
      xf.a_yy <= 16'sd1 <<< FRAC_BITS;
      sh_x <= '0;
      sh_y <= '0;
      ce_x <= '0;
      ce_y <= '0;
      xf.off_x <= '0;
      xf.off_y <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          {1'b0, CFG_A_XX}:     xf.a_xx <= cfg_data[15:0];
          {1'b0, CFG_A_XY}:     xf.a_xy <= cfg_data[15:0];
          {1'b0, CFG_A_YX}:     xf.a_yx <= cfg_data[15:0];
          {1'b0, CFG_A_YY}:     xf.a_yy <= cfg_data[15:0];
          {1'b0, CFG_SHIFT_X}:  begin
            sh_x <= cfg_data;
            xf.off_x <= {cfg_data[23], cfg_data} + {ce_x[23], ce_x};
          end
          {1'b0, CFG_SHIFT_Y}:  begin
            sh_y <= cfg_data;
            xf.off_y <= {cfg_data[23], cfg_data} + {ce_y[23], ce_y};
          end
          {1'b0, CFG_CENTER_X}: begin
            ce_x <= cfg_data;
            xf.off_x <= {sh_x[23], sh_x} + {cfg_data[23], cfg_data};
          end
          {1'b0, CFG_CENTER_Y}: begin
            ce_y <= cfg_data;
            xf.off_y <= {sh_y[23], sh_y} + {cfg_data[23], cfg_data};
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    qx = {bx[POS_W-1], bx};
    qy = {by[POS_W-1], by};
    case (sidx)
      2'd0: qx = bx + 13'sd1;
      2'd1: qx = bx - 13'sd1;
      2'd2: qy = by + 13'sd1;
      default: qy = by - 13'sd1;
    endcase
    if (kind == REQ_SAMPLE) begin
      qx = bx;
      qy = by;
    end
  end

  abs_map u_map (.clk(clk), .xf(xf), .qx(qx), .qy(qy), .pt(pt));

  always_comb begin
    rx = {ix[MAP_W-FRAC_BITS-1], ix} + (MAP_W-FRAC_BITS+1)'(rcnt[0] && fx != '0);
    ry = {iy[MAP_W-FRAC_BITS-1], iy} + (MAP_W-FRAC_BITS+1)'(rcnt[1]);
    rin = (rx >= 0) && (rx < IMG_WIDTH) && (ry >= 0) && (ry < IMG_HEIGHT);
    ram_we = 1'b0;
    ram_addr = AW'(ry * IMG_WIDTH + rx);
    if (state == S_IDLE) begin
      ram_we = in_valid && req_type == REQ_WRITE && pos_x >= 0 && pos_x < IMG_WIDTH
               && pos_y >= 0 && pos_y < IMG_HEIGHT;
      ram_addr = AW'(pos_y * IMG_WIDTH + pos_x);
    end
  end

  abs_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(pixel_in), .rdata(ram_rdata)
  );

  logic [3:0] pin;

  assign sval = (fy == '0) ? SAMPLE_W'(r1) : SAMPLE_W'((t1 + t2) >> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && (req_type == REQ_SAMPLE || req_type == REQ_GRAD)) begin
            kind <= req_type;
            bx <= pos_x;
            by <= pos_y;
            sidx <= '0;
            mcnt <= '0;
            state <= S_MAP;
          end
        end
        S_MAP: begin
          mcnt <= mcnt + 2'd1;
          if (mcnt == 2'd2) begin
            ix <= pt.px[MAP_W-1:FRAC_BITS];
            iy <= pt.py[MAP_W-1:FRAC_BITS];
            fx <= pt.px[FRAC_BITS-1:0];
            fy <= pt.py[FRAC_BITS-1:0];
            rcnt <= '0;
            state <= S_RD;
          end
        end
        S_RD: begin
          rcnt <= rcnt + 3'd1;
          pin[rcnt[1:0]] <= rin;
          if (rcnt != 3'd0) begin
            p[rcnt[1:0] - 2'd1] <= pin[rcnt[1:0] - 2'd1] ? ram_rdata : '0;
          end
          if (rcnt == 3'd4) begin
            state <= S_M1;
          end
        end
        S_M1: begin
          m0 <= (PIX_W+FRAC_BITS+1)'((ONE - fx) * p[0]);
          m1 <= (PIX_W+FRAC_BITS+1)'(fx * p[1]);
          m2 <= (PIX_W+FRAC_BITS+1)'((ONE - fx) * p[2]);
          m3 <= (PIX_W+FRAC_BITS+1)'(fx * p[3]);
          state <= S_M2;
        end
        S_M2: begin
          r1 <= m0 + m1;
          r2 <= m2 + m3;
          state <= S_M3;
        end
        S_M3: begin
          t1 <= (ONE - fy) * r1;
          t2 <= fy * r2;
          state <= S_ACC;
        end
        S_ACC: begin
          if (kind == REQ_SAMPLE) begin
            result_kind <= 1'b0;
            sample_value <= sval;
            grad_x <= '0;
            grad_y <= '0;
            state <= S_OUT;
          end else begin
            case (sidx)
              2'd0: s0 <= sval;
              2'd1: dx <= (GRAD_W+1)'(s0) - (GRAD_W+1)'(sval);
              2'd2: s0 <= sval;
              default: ;
            endcase
            sidx <= sidx + 2'd1;
            mcnt <= '0;
            state <= S_MAP;
            if (sidx == 2'd3) begin
              result_kind <= 1'b1;
              sample_value <= '0;
              grad_x <= dx[GRAD_W-1:0];
              grad_y <= GRAD_W'((GRAD_W+1)'(s0) - (GRAD_W+1)'(sval));
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/abs_checker.sv =====
// ----------------------------------------------------------------------------
// abs_checker
// Port-level checks for the affine bilinear sampler.
// ----------------------------------------------------------------------------
module abs_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic result_kind,
  input logic [27:0] sample_value,
  input logic [28:0] grad_x,
  input logic cfg_ready
);

  a_no_take_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample_value))
    else $error("result dropped under stall");

  a_sample_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result_kind |-> grad_x == '0) else $error("sample has gradient");

  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !out_valid) else $error("config open while busy");

endmodule

bind affine_bilinear_sampler_top abs_checker u_abs_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .result_kind(result_kind),
  .sample_value(sample_value), .grad_x(grad_x), .cfg_ready(cfg_ready)
);
